// ----- hdl/aeba_pkg.sv -----
// ----------------------------------------------------------------------------
// aeba_pkg
// Shared types, geometry constants and beam layout tables for the array
// element beam assigner.
// ----------------------------------------------------------------------------
package aeba_pkg;

  // Array geometry
  localparam int ARRAY_SIDE      = 64;
  localparam int BLOCKS_PER_SIDE = 2;
  localparam int BLK_SIZE        = ARRAY_SIDE / BLOCKS_PER_SIDE;
  localparam int EDGE_LO         = ARRAY_SIDE / 4;
  localparam int EDGE_HI         = 3 * (ARRAY_SIDE / 4);
  localparam logic BLK_SIZE_ODD  = 1'((BLK_SIZE % 2) != 0);

  localparam int COORD_W = 6;
  localparam int CFG_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] REG_HOR   = 2'd0;
  localparam logic [CFG_W-1:0] REG_TIGHT = 2'd1;
  localparam logic [CFG_W-1:0] REG_DIAG  = 2'd2;

  // Diagonal classes
  localparam logic [1:0] DIAG_NONE = 2'd0;
  localparam logic [1:0] DIAG_MID  = 2'd1;
  localparam logic [1:0] DIAG_FULL = 2'd2;
  localparam logic [1:0] DIAG_TIGHT_LAYOUT = 2'd3;

  // Mode settings seen by the datapath
  typedef struct packed {
    logic       hor;
    logic       tight;
    logic [1:0] diag;   // clamped to 0..2
  } cfg_t;

  // Stage 1 result: raw subarray and edge flags
  typedef struct packed {
    logic       in_range;
    logic [3:0] raw;
    logic       x_lo;   // x below one quarter
    logic       x_hi;   // x at or above three quarters
    logic       y_lo;
    logic       y_hi;
  } geom_t;

  // Stage 2 result: remapped subarray
  typedef struct packed {
    logic       en;
    logic [3:0] sub;
  } rmp_t;

  // Beam layouts [layout][row][col]; NO_BEAM marks an empty entry.
  // Layouts 0..2 vertical by diagonal class, 3 vertical tight,
  // 4..6 horizontal by diagonal class, 7 horizontal tight.
  localparam logic [4:0] NO_BEAM = 5'd31;
  localparam logic [4:0] BEAM_TBL [8][4][4] = '{
    '{'{5'd0, 5'd2, 5'd10, 5'd12}, '{5'd1, 5'd3, 5'd11, 5'd13},
      '{5'd4, 5'd5, 5'd8, 5'd9},   '{5'd6, 5'd7, NO_BEAM, NO_BEAM}},
    '{'{5'd0, 5'd1, 5'd11, NO_BEAM}, '{5'd3, 5'd2, 5'd10, 5'd9},
      '{5'd5, 5'd4, NO_BEAM, 5'd8},  '{NO_BEAM, 5'd6, 5'd7, NO_BEAM}},
    '{'{5'd0, 5'd1, 5'd12, NO_BEAM}, '{5'd3, 5'd2, 5'd11, 5'd10},
      '{5'd4, 5'd5, 5'd8, 5'd9},     '{NO_BEAM, 5'd6, 5'd7, NO_BEAM}},
    '{'{5'd0, 5'd2, 5'd1, 5'd3},     '{5'd6, 5'd4, 5'd5, 5'd7},
      '{5'd8, 5'd10, 5'd9, 5'd11},   '{NO_BEAM, 5'd12, 5'd13, NO_BEAM}},
    '{'{5'd0, 5'd2, 5'd4, 5'd6},     '{5'd1, 5'd3, 5'd5, 5'd7},
      '{5'd10, 5'd12, 5'd8, NO_BEAM}, '{5'd11, 5'd13, 5'd9, NO_BEAM}},
    '{'{5'd0, 5'd3, 5'd5, NO_BEAM},  '{5'd1, 5'd2, 5'd4, 5'd6},
      '{5'd11, 5'd10, NO_BEAM, 5'd7}, '{NO_BEAM, 5'd9, 5'd8, NO_BEAM}},
    '{'{5'd0, 5'd3, 5'd4, NO_BEAM},  '{5'd1, 5'd2, 5'd5, 5'd6},
      '{5'd12, 5'd11, 5'd8, 5'd7},   '{NO_BEAM, 5'd10, 5'd9, NO_BEAM}},
    '{'{5'd0, 5'd6, 5'd8, NO_BEAM},  '{5'd2, 5'd4, 5'd10, 5'd12},
      '{5'd1, 5'd5, 5'd9, 5'd13},    '{5'd3, 5'd7, 5'd11, NO_BEAM}}
  };

endpackage

// ----- hdl/aeba_index.sv -----
// ----------------------------------------------------------------------------
// aeba_index
// Forms the interleaved subarray number and the quarter edge flags of one
// element coordinate.
// ----------------------------------------------------------------------------
module aeba_index import aeba_pkg::*; (
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  output geom_t              geom_o
);

  logic xb, yb, xs, ys;

  // Block index is 0 or 1; sub index is the parity inside the block
  assign xb = int'(col_i) >= BLK_SIZE;
  assign yb = int'(row_i) >= BLK_SIZE;
  assign xs = col_i[0] ^ (xb & BLK_SIZE_ODD);
  assign ys = row_i[0] ^ (yb & BLK_SIZE_ODD);

  always_comb begin
    geom_o.in_range = (int'(col_i) < ARRAY_SIDE) && (int'(row_i) < ARRAY_SIDE);
    geom_o.raw      = {xb, xs, yb, ys};
    geom_o.x_lo     = int'(col_i) < EDGE_LO;
    geom_o.x_hi     = int'(col_i) >= EDGE_HI;
    geom_o.y_lo     = int'(row_i) < EDGE_LO;
    geom_o.y_hi     = int'(row_i) >= EDGE_HI;
  end

endmodule

// ----- hdl/aeba_remap.sv -----
// ----------------------------------------------------------------------------
// aeba_remap
// Applies the mode dependent remap and disable rules to a raw subarray.
// ----------------------------------------------------------------------------
module aeba_remap import aeba_pkg::*; (
  input  cfg_t  cfg_i,
  input  geom_t geom_i,
  output rmp_t  rmp_o
);

  logic       en;
  logic [3:0] d;

  always_comb begin
    en = geom_i.in_range;
    d  = geom_i.raw;
    if (!cfg_i.tight && !cfg_i.hor) begin
      // Vertical motion, wide layouts
      if (cfg_i.diag == DIAG_NONE) begin
        if (d[1:0] == 2'd3) begin
          if (geom_i.x_lo || geom_i.x_hi) en = 1'b0;
          else d[3] = 1'b0;
        end
      end else begin
        if (d == 4'd1 && geom_i.y_lo) en = 1'b0;
        else if (d == 4'd3 && !geom_i.y_hi) d = 4'd1;
        else if (d == 4'd3) en = 1'b0;
        else if (d == 4'd7 && geom_i.x_lo) en = 1'b0;
        else if (d == 4'd15 && !geom_i.x_hi) d = 4'd7;
        else if (d == 4'd15) en = 1'b0;
        else if (d == 4'd14 && geom_i.y_hi) en = 1'b0;
        else if (d == 4'd12 && !geom_i.y_lo) d = 4'd14;
        else if (d == 4'd12) en = 1'b0;
        if (cfg_i.diag == DIAG_MID) begin
          if (d == 4'd2 && geom_i.x_lo) en = 1'b0;
          else if (d == 4'd10 && !geom_i.x_hi) d = 4'd2;
          else if (d == 4'd10) en = 1'b0;
        end
      end
    end else if (!cfg_i.tight) begin
      // Horizontal motion, wide layouts
      if (cfg_i.diag == DIAG_NONE) begin
        if (d >= 4'd12) begin
          if (geom_i.y_lo || geom_i.y_hi) en = 1'b0;
          else if (d >= 4'd14) d = d - 4'd2;
        end
      end else begin
        if (d == 4'd4 && geom_i.x_lo) en = 1'b0;
        else if (d == 4'd12 && !geom_i.x_hi) d = 4'd4;
        else if (d == 4'd12) en = 1'b0;
        else if (d == 4'd13 && geom_i.y_lo) en = 1'b0;
        else if (d == 4'd15 && !geom_i.y_hi) d = 4'd13;
        else if (d == 4'd15) en = 1'b0;
        else if (d == 4'd11 && geom_i.x_hi) en = 1'b0;
        else if (d == 4'd3 && !geom_i.x_lo) d = 4'd11;
        else if (d == 4'd3) en = 1'b0;
        if (cfg_i.diag == DIAG_MID) begin
          if (d == 4'd8 && geom_i.y_lo) en = 1'b0;
          else if (d == 4'd10 && !geom_i.y_hi) d = 4'd8;
          else if (d == 4'd10) en = 1'b0;
        end
      end
    end else if (cfg_i.hor) begin
      // Horizontal motion, tight layout
      if ((d == 4'd4 || d == 4'd7) && geom_i.x_lo) en = 1'b0;
      else if (d == 4'd12 && !geom_i.x_hi) d = 4'd4;
      else if (d == 4'd15 && !geom_i.x_hi) d = 4'd7;
      else if (d == 4'd12 || d == 4'd15) en = 1'b0;
    end else begin
      // Vertical motion, tight layout
      if ((d == 4'd1 || d == 4'd13) && geom_i.y_lo) en = 1'b0;
      else if (d == 4'd3 && !geom_i.y_hi) d = 4'd1;
      else if (d == 4'd15 && !geom_i.y_hi) d = 4'd13;
      else if (d == 4'd3 || d == 4'd15) en = 1'b0;
    end
    rmp_o.en  = en;
    rmp_o.sub = d;
  end

endmodule

// ----- hdl/aeba_beam_lut.sv -----
// ----------------------------------------------------------------------------
// aeba_beam_lut
// Looks up the beam of a remapped subarray in the layout picked by the mode.
// ----------------------------------------------------------------------------
module aeba_beam_lut import aeba_pkg::*; (
  input  cfg_t       cfg_i,
  input  rmp_t       rmp_i,
  output logic       enabled_o,
  output logic [3:0] beam_o,
  output logic [3:0] sub_o
);

  logic [2:0] layout;
  logic [4:0] entry;

  // Tight layouts ignore the diagonal class
  assign layout = {cfg_i.hor, cfg_i.tight ? DIAG_TIGHT_LAYOUT : cfg_i.diag};
  // Column-major: row is the low pair, column the high pair
  assign entry  = BEAM_TBL[layout][rmp_i.sub[1:0]][rmp_i.sub[3:2]];

  // Zero the fields of a disabled element
  always_comb begin
    enabled_o = rmp_i.en && (entry != NO_BEAM);
    beam_o    = enabled_o ? entry[3:0] : 4'd0;
    sub_o     = enabled_o ? rmp_i.sub : 4'd0;
  end

endmodule

// ----- hdl/array_element_beam_assigner_unit.sv -----
// ----------------------------------------------------------------------------
// array_element_beam_assigner_unit
// Maps an element coordinate of the phased array to its driving beam.
// ----------------------------------------------------------------------------
// Takes one element coordinate per cycle and returns its beam through a
// three stage pipeline: subarray indexing, mode remap, and beam table
// lookup, each followed by a register with its own valid bit.
// Throughput is one element per clock; a stall at the output backs up the
// stages without losing or repeating any element. The mode registers are
// written through the plain write port (index 0 horizontal mode, 1 tight
// mode, 2 diagonal class, where class 3 behaves as 2) and must only change
// while the pipeline is empty.
module array_element_beam_assigner_unit import aeba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_idx_i,
  input  logic [1:0]         cfg_data_i,
  // Element input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] element_col_i,
  input  logic [COORD_W-1:0] element_row_i,
  // Beam result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               element_enabled_o,
  output logic [3:0]         beam_index_o,
  output logic [3:0]         subarray_index_o
);

  logic       hor_q, tight_q;
  logic [1:0] diag_q;
  cfg_t       cfg;

  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  geom_t s1_geom_d, s1_geom_q;
  rmp_t  s2_rmp_d, s2_rmp_q;
  logic  s3_en_d, s3_en_q;
  logic [3:0] s3_beam_d, s3_beam_q, s3_sub_d, s3_sub_q;
  logic  s1_ld, s2_ld, s3_ld;

  // Mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hor_q   <= 1'b0;
      tight_q <= 1'b0;
      diag_q  <= DIAG_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOR:   hor_q   <= cfg_data_i[0];
        REG_TIGHT: tight_q <= cfg_data_i[0];
        REG_DIAG:  diag_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the unused diagonal class onto the diagonal one
  always_comb begin
    cfg.hor   = hor_q;
    cfg.tight = tight_q;
    cfg.diag  = (diag_q == DIAG_TIGHT_LAYOUT) ? DIAG_FULL : diag_q;
  end

  // Stage load enables: a stage loads when empty or when its successor loads
  assign s3_ld      = !s3_valid_q || out_ready_i;
  assign s2_ld      = !s2_valid_q || s3_ld;
  assign s1_ld      = !s1_valid_q || s2_ld;
  assign in_ready_o = s1_ld;

  aeba_index u_index (
    .col_i  (element_col_i),
    .row_i  (element_row_i),
    .geom_o (s1_geom_d)
  );

  aeba_remap u_remap (
    .cfg_i  (cfg),
    .geom_i (s1_geom_q),
    .rmp_o  (s2_rmp_d)
  );

  aeba_beam_lut u_beam_lut (
    .cfg_i     (cfg),
    .rmp_i     (s2_rmp_q),
    .enabled_o (s3_en_d),
    .beam_o    (s3_beam_d),
    .sub_o     (s3_sub_d)
  );

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ld) s1_valid_q <= in_valid_i;
      if (s2_ld) s2_valid_q <= s1_valid_q;
      if (s3_ld) s3_valid_q <= s2_valid_q;
    end
  end

  // Advance payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (s1_ld && in_valid_i) s1_geom_q <= s1_geom_d;
    if (s2_ld && s1_valid_q) s2_rmp_q <= s2_rmp_d;
    if (s3_ld && s2_valid_q) begin
      s3_en_q   <= s3_en_d;
      s3_beam_q <= s3_beam_d;
      s3_sub_q  <= s3_sub_d;
    end
  end

  assign out_valid_o       = s3_valid_q;
  assign element_enabled_o = s3_en_q;
  assign beam_index_o      = s3_beam_q;
  assign subarray_index_o  = s3_sub_q;

  // A disabled element carries zero beam and subarray
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !element_enabled_o |-> beam_index_o == 4'd0 && subarray_index_o == 4'd0)
    else $error("disabled element with nonzero fields");

  // Beam numbers stay inside the layout range
  a_beam_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> beam_index_o <= 4'd13)
    else $error("beam index out of range");

  // A blocked first stage keeps its element
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ld |=> s1_valid_q && $stable(s1_geom_q))
    else $error("stage 1 element lost under stall");

endmodule

// ----- bench/array_element_beam_assigner_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_element_beam_assigner_unit_tb
// Self-checking bench for the phased array element beam assigner.
// ----------------------------------------------------------------------------
// A driver streams element coordinates from a queue filled by the stimulus
// process. Each accepted coordinate is run through a local beam predictor
// that tracks the mode registers, and the monitor compares every result
// transfer, field by field, with the oldest prediction. The run covers the
// reset settings with directed coordinates, then every mode combination
// with random coordinates biased toward block and quarter edges, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module array_element_beam_assigner_unit_tb import aeba_pkg::*; ();

  localparam int SIDE          = 64;
  localparam int BLOCK         = SIDE / 2;
  localparam int QUARTER       = SIDE / 4;
  localparam int THREE_QUARTER = 3 * (SIDE / 4);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 160;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int NUM_PHASES    = 16;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } element_coord_t;

  typedef struct packed {
    logic       en;
    logic [3:0] beam;
    logic [3:0] sub;
  } beam_result_t;

  typedef struct packed {
    element_coord_t coord;
    beam_result_t   res;
  } beam_expect_t;

  // Beam layouts [layout][row][col]; -1 marks an empty slot
  int beam_layouts [8][4][4] = '{
    '{'{0, 2, 10, 12}, '{1, 3, 11, 13}, '{4, 5, 8, 9},   '{6, 7, -1, -1}},
    '{'{0, 1, 11, -1}, '{3, 2, 10, 9},  '{5, 4, -1, 8},  '{-1, 6, 7, -1}},
    '{'{0, 1, 12, -1}, '{3, 2, 11, 10}, '{4, 5, 8, 9},   '{-1, 6, 7, -1}},
    '{'{0, 2, 1, 3},   '{6, 4, 5, 7},   '{8, 10, 9, 11}, '{-1, 12, 13, -1}},
    '{'{0, 2, 4, 6},   '{1, 3, 5, 7},   '{10, 12, 8, -1}, '{11, 13, 9, -1}},
    '{'{0, 3, 5, -1},  '{1, 2, 4, 6},   '{11, 10, -1, 7}, '{-1, 9, 8, -1}},
    '{'{0, 3, 4, -1},  '{1, 2, 5, 6},   '{12, 11, 8, 7}, '{-1, 10, 9, -1}},
    '{'{0, 6, 8, -1},  '{2, 4, 10, 12}, '{1, 5, 9, 13},  '{3, 7, 11, -1}}
  };

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic [CFG_W-1:0]   cfg_idx_i         = '0;
  logic [1:0]         cfg_data_i        = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [COORD_W-1:0] element_col_i     = '0;
  logic [COORD_W-1:0] element_row_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic               element_enabled_o;
  logic [3:0]         beam_index_o;
  logic [3:0]         subarray_index_o;

  // Local copy of the mode registers
  logic       mode_hor   = 1'b0;
  logic       mode_tight = 1'b0;
  logic [1:0] mode_diag  = DIAG_NONE;

  element_coord_t pending_coords [$];
  beam_expect_t   expected_beams [$];
  element_coord_t next_coord;
  beam_expect_t   sent_beam;
  beam_expect_t   oldest_beam;

  logic idle_on      = 1'b1;
  logic hold_request = 1'b0;
  logic hold_taken;
  int   send_gap;
  int   recv_gap;
  int   hold_left;
  int   mismatch_count = 0;
  int   cycle_count    = 0;

  array_element_beam_assigner_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_col_i    (element_col_i),
    .element_row_i    (element_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_enabled_o(element_enabled_o),
    .beam_index_o     (beam_index_o),
    .subarray_index_o (subarray_index_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply the mode rules to a raw subarray number; -1 means disabled
  function automatic int remap_subarray(int d, int x, int y, int dc);
    if (!mode_tight && !mode_hor) begin
      if (dc == 0) begin
        if ((d & 3) == 3) begin
          if (x < QUARTER || x >= THREE_QUARTER) d = -1;
          else if (d >= 8) d = d - 8;
        end
      end else begin
        if (d == 1 && y < QUARTER) d = -1;
        else if (d == 3 && y < THREE_QUARTER) d = 1;
        else if (d == 3) d = -1;
        else if (d == 7 && x < QUARTER) d = -1;
        else if (d == 15 && x < THREE_QUARTER) d = 7;
        else if (d == 15) d = -1;
        else if (d == 14 && y >= THREE_QUARTER) d = -1;
        else if (d == 12 && y >= QUARTER) d = 14;
        else if (d == 12) d = -1;
        if (dc == 1) begin
          if (d == 2 && x < QUARTER) d = -1;
          else if (d == 10 && x < THREE_QUARTER) d = 2;
          else if (d == 10) d = -1;
        end
      end
    end else if (!mode_tight && mode_hor) begin
      if (dc == 0) begin
        if (d >= 12) begin
          if (y < QUARTER || y >= THREE_QUARTER) d = -1;
          else if (d >= 14) d = d - 2;
        end
      end else begin
        if (d == 4 && x < QUARTER) d = -1;
        else if (d == 12 && x < THREE_QUARTER) d = 4;
        else if (d == 12) d = -1;
        else if (d == 13 && y < QUARTER) d = -1;
        else if (d == 15 && y < THREE_QUARTER) d = 13;
        else if (d == 15) d = -1;
        else if (d == 11 && x >= THREE_QUARTER) d = -1;
        else if (d == 3 && x >= QUARTER) d = 11;
        else if (d == 3) d = -1;
        if (dc == 1) begin
          if (d == 8 && y < QUARTER) d = -1;
          else if (d == 10 && y < THREE_QUARTER) d = 8;
          else if (d == 10) d = -1;
        end
      end
    end else if (mode_hor) begin
      if ((d == 4 || d == 7) && x < QUARTER) d = -1;
      else if (d == 12 && x < THREE_QUARTER) d = 4;
      else if (d == 15 && x < THREE_QUARTER) d = 7;
      else if (d == 12 || d == 15) d = -1;
    end else begin
      if ((d == 1 || d == 13) && y < QUARTER) d = -1;
      else if (d == 3 && y < THREE_QUARTER) d = 1;
      else if (d == 15 && y < THREE_QUARTER) d = 13;
      else if (d == 3 || d == 15) d = -1;
    end
    return d;
  endfunction

  // Work out the beam driving one element under the current modes
  function automatic beam_result_t predict_beam(element_coord_t c);
    int x, y, dc, d, layout, b;
    beam_result_t r;
    x  = c.col;
    y  = c.row;
    dc = (mode_diag > DIAG_FULL) ? 2 : int'(mode_diag);
    r  = '0;
    if (x < SIDE && y < SIDE) begin
      d = ((y / BLOCK) * 2 + (y % BLOCK) % 2) + ((x / BLOCK) * 2 + (x % BLOCK) % 2) * 4;
      d = remap_subarray(d & 15, x, y, dc);
      if (d >= 0) begin
        layout = (mode_hor ? 4 : 0) + (mode_tight ? 3 : dc);
        b = beam_layouts[layout][d % 4][d / 4];
        if (b >= 0) begin
          r.en   = 1'b1;
          r.beam = b[3:0];
          r.sub  = d[3:0];
        end
      end
    end
    return r;
  endfunction

  // Coordinates biased toward block and quarter edges
  function automatic logic [COORD_W-1:0] pick_coord();
    int k;
    if ($urandom_range(0, 3) != 0) return COORD_W'($urandom_range(0, SIDE - 1));
    k = $urandom_range(0, 7);
    case (k)
      0: return COORD_W'($urandom_range(0, 1));
      1: return COORD_W'($urandom_range(QUARTER - 2, QUARTER + 1));
      2: return COORD_W'($urandom_range(BLOCK - 2, BLOCK + 1));
      3: return COORD_W'($urandom_range(THREE_QUARTER - 2, THREE_QUARTER + 1));
      default: return COORD_W'($urandom_range(SIDE - 2, SIDE - 1));
    endcase
  endfunction

  task automatic push_coord(int x, int y);
    element_coord_t c;
    c.col = COORD_W'(x);
    c.row = COORD_W'(y);
    pending_coords = {pending_coords, c};
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) push_coord(pick_coord(), pick_coord());
  endtask

  // Write one mode register and track it locally
  task automatic write_mode(logic [CFG_W-1:0] idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_HOR:   mode_hor   = val[0];
      REG_TIGHT: mode_tight = val[0];
      REG_DIAG:  mode_diag  = val;
      default: ;
    endcase
  endtask

  // Hold until every coordinate is sent and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_coords.size() != 0 || in_valid_i || expected_beams.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver: offer pending coordinates, predict each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      element_col_i <= '0;
      element_row_i <= '0;
      send_gap      <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent_beam.coord.col = element_col_i;
        sent_beam.coord.row = element_row_i;
        sent_beam.res       = predict_beam(sent_beam.coord);
        expected_beams      = {expected_beams, sent_beam};
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offered coordinate
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap   <= $urandom_range(0, 12);
        in_valid_i <= 1'b0;
      end else if (pending_coords.size() != 0) begin
        next_coord    = pending_coords.pop_front();
        element_col_i <= next_coord.col;
        element_row_i <= next_coord.row;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beams.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: en=%0b beam=%0d sub=%0d",
                     element_enabled_o, beam_index_o, subarray_index_o);
          mismatch_count++;
        end else begin
          oldest_beam = expected_beams.pop_front();
          if (element_enabled_o !== oldest_beam.res.en ||
              beam_index_o !== oldest_beam.res.beam ||
              subarray_index_o !== oldest_beam.res.sub) begin
            if (mismatch_count < 10) begin
              $display("mismatch at (%0d,%0d) modes h=%0b t=%0b d=%0d:",
                       oldest_beam.coord.col, oldest_beam.coord.row,
                       mode_hor, mode_tight, mode_diag);
              $display("  expected en=%0b beam=%0d sub=%0d, got en=%0b beam=%0d sub=%0d",
                       oldest_beam.res.en, oldest_beam.res.beam, oldest_beam.res.sub,
                       element_enabled_o, beam_index_o, subarray_index_o);
            end
            mismatch_count++;
          end
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken  <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap    <= $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL array_element_beam_assigner_unit");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [3:0] raw;
    logic [1:0] diag_val;
    int half;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, quarter edges and every raw subarray at reset modes
    push_coord(0, 0);
    push_coord(SIDE - 1, SIDE - 1);
    push_coord(0, SIDE - 1);
    push_coord(SIDE - 1, 0);
    push_coord(QUARTER - 1, QUARTER);
    push_coord(QUARTER, QUARTER - 1);
    push_coord(THREE_QUARTER - 1, THREE_QUARTER);
    push_coord(THREE_QUARTER, THREE_QUARTER - 1);
    for (int r = 0; r < 16; r++) begin
      raw = 4'(r);
      push_coord(raw[3] * BLOCK + QUARTER + raw[2], raw[1] * BLOCK + QUARTER - 2 + raw[0]);
    end

    // Random: every mode combination, diagonal class 3 included
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      idle_on  = !(p == 4 || p >= NUM_PHASES - 2);
      diag_val = 2'((p >> 1) & 3);
      write_mode(REG_HOR, {1'($urandom_range(0, 1)), 1'(p & 1)});
      write_mode(REG_TIGHT, {1'($urandom_range(0, 1)), 1'(p >> 3)});
      write_mode(REG_DIAG, diag_val);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      // Hold the output off for a long stretch while the input keeps coming
      if (p == 2) hold_request = 1'b1;
      half = $urandom_range(25, 37);
      push_random(half);
      // Let the block run dry mid-phase before resuming
      if (p == 6) wait_drained();
      push_random($urandom_range(25, 37));
    end

    wait_drained();
    if (mismatch_count == 0 && expected_beams.size() == 0) begin
      $display("PASS array_element_beam_assigner_unit");
    end else begin
      $display("FAIL array_element_beam_assigner_unit");
    end
    $finish;
  end

endmodule
